// ===== rtl/mbrm_pkg.sv =====
// Shared types, codes and default sizes for the Modbus register map.
package mbrm_pkg;

   localparam int HOLDING_REGS_DEF  = 128;
   localparam int INPUT_REGS_DEF    = 4;
   localparam int COIL_BITS_DEF     = 64;
   localparam int DISCRETE_BITS_DEF = 64;
   localparam int MAX_RUN_DEF       = 64;

   localparam int ADDR_W  = 16;
   localparam int COUNT_W = 10;
   localparam int DATA_W  = 16;
   localparam int CSR_W   = 2;

   localparam logic [ADDR_W-1:0] INPUT_BASE_RST    = 16'd1000;
   localparam logic [ADDR_W-1:0] HOLDING_BASE_RST  = 16'd2000;
   localparam logic [ADDR_W-1:0] COIL_BASE_RST     = 16'd0;
   localparam logic [ADDR_W-1:0] DISCRETE_BASE_RST = 16'd0;

   localparam logic [CSR_W-1:0] CSR_INPUT_BASE    = 2'd0;
   localparam logic [CSR_W-1:0] CSR_HOLDING_BASE  = 2'd1;
   localparam logic [CSR_W-1:0] CSR_COIL_BASE     = 2'd2;
   localparam logic [CSR_W-1:0] CSR_DISCRETE_BASE = 2'd3;

   typedef enum logic [2:0] {
      MODE_RD_INPUT      = 3'd0,
      MODE_RD_HOLDING    = 3'd1,
      MODE_WR_HOLDING    = 3'd2,
      MODE_RD_COILS      = 3'd3,
      MODE_WR_COILS      = 3'd4,
      MODE_RD_DISCRETE   = 3'd5,
      MODE_LOAD_INPUT    = 3'd6,
      MODE_LOAD_DISCRETE = 3'd7
   } mode_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WORD_RD,
      ST_WORD_DATA,
      ST_BIT_RD,
      ST_BIT_TAKE,
      ST_BIT_EMIT,
      ST_BIT_WR,
      ST_RESULT
   } state_type;

   typedef struct packed {
      mode_type            mode;
      logic                start_req;
      logic [ADDR_W-1:0]   address;
      logic [COUNT_W-1:0]  count;
      logic [DATA_W-1:0]   write_data;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic              status;
      logic              last;
   } rsp_type;

endpackage

// ===== rtl/modbus_register_map.sv =====
// Top level of the Modbus slave register map: decode, run control and the two stores.
//
// Usage: requests enter on req_valid/req_ready as one req_data beat per item; results
// leave on rsp_valid/rsp_ready as rsp_data beats. Base addresses are written through
// csr_we/csr_index/csr_wdata while the block is idle.
// Holding and input registers live in one word memory; coils and discrete inputs live
// in one bit memory. Both have a registered read.
// Steps per item, set by the registered reads and the one-bit port of the bit memory:
//   register read: accept, then a read state and a data state per word;
//   coil or discrete read: accept, then read and take states per bit, emit per byte beat;
//   holding write beat: written on acceptance; the final beat is followed by an acknowledge;
//   coil write beat or discrete load: accept, then a write state per bit, then a reply if due;
//   input load and refused requests: accept, then a result state.
// Reset: synchronous; afterwards a clearing pass zeroes both memories, one entry per
// cycle; req_ready stays low meanwhile, CSR writes are taken as ever.
// Stall: one output register holds a result until rsp_ready; the engine waits on it.
module modbus_register_map #(
   parameter int HOLDING_REGS  = mbrm_pkg::HOLDING_REGS_DEF,
   parameter int INPUT_REGS    = mbrm_pkg::INPUT_REGS_DEF,
   parameter int COIL_BITS     = mbrm_pkg::COIL_BITS_DEF,
   parameter int DISCRETE_BITS = mbrm_pkg::DISCRETE_BITS_DEF,
   parameter int MAX_RUN       = mbrm_pkg::MAX_RUN_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  mbrm_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mbrm_pkg::rsp_type             rsp_data,
   input  logic                          csr_we,
   input  logic [mbrm_pkg::CSR_W-1:0]    csr_index,
   input  logic [mbrm_pkg::DATA_W-1:0]   csr_wdata
);

   localparam int WORD_DEPTH = HOLDING_REGS + INPUT_REGS;
   localparam int BIT_DEPTH  = COIL_BITS + DISCRETE_BITS;
   localparam int WORD_AW    = $clog2(WORD_DEPTH);
   localparam int BIT_AW     = $clog2(BIT_DEPTH);
   localparam int CLEAR_LEN  = (WORD_DEPTH > BIT_DEPTH) ? WORD_DEPTH : BIT_DEPTH;
   localparam int CLR_W      = $clog2(CLEAR_LEN);
   localparam int AW         = mbrm_pkg::ADDR_W;
   localparam int CW         = mbrm_pkg::COUNT_W;
   localparam int DW         = mbrm_pkg::DATA_W;

   // configuration
   logic [AW-1:0] input_base_ff, holding_base_ff, coil_base_ff, discrete_base_ff;

   // control
   mbrm_pkg::state_type state_ff, state_in;
   logic [CLR_W-1:0]    clr_ptr_ff, clr_ptr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   mbrm_pkg::rsp_type   rsp_beat_ff, rsp_beat_in;

   // open write run
   logic                run_open_ff, run_open_in;
   mbrm_pkg::mode_type  run_mode_ff, run_mode_in;
   logic [CW-1:0]       run_left_ff, run_left_in;
   logic [WORD_AW-1:0]  run_word_ptr_ff, run_word_ptr_in;
   logic [BIT_AW-1:0]   run_bit_ptr_ff, run_bit_ptr_in;

   // engine
   logic [WORD_AW-1:0]  eng_word_ptr_ff, eng_word_ptr_in;
   logic [BIT_AW-1:0]   eng_bit_ptr_ff, eng_bit_ptr_in;
   logic [CW-1:0]       eng_left_ff, eng_left_in;
   logic [2:0]          bit_idx_ff, bit_idx_in;
   logic [2:0]          last_idx_ff, last_idx_in;
   logic [7:0]          acc_ff, acc_in;
   logic [7:0]          wbyte_ff, wbyte_in;
   logic                reply_ff, reply_in;
   logic                res_status_ff, res_status_in;
   logic                emit_last_ff, emit_last_in;

   // memories
   logic [DW-1:0]       word_mem_ff [WORD_DEPTH];
   logic                bit_mem_ff [BIT_DEPTH];
   logic [DW-1:0]       word_rd_ff;
   logic                bit_rd_ff;
   logic                word_we, word_re, bit_we, bit_re;
   logic [WORD_AW-1:0]  word_waddr, word_raddr;
   logic [BIT_AW-1:0]   bit_waddr, bit_raddr;
   logic [DW-1:0]       word_wdata;
   logic                bit_wdata;

   // request decode
   logic                req_fire, out_free, sel_bits, cnt_ok, run_ok, cont_match;
   logic                emit;
   mbrm_pkg::rsp_type   emit_beat;
   logic [AW-1:0]       sel_base, offset16;
   logic [AW:0]         sel_limit, end_addr;
   logic [3:0]          first_bits, cont_bits;

   assign req_ready = (state_ff == mbrm_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_beat_ff;

   always_comb begin
      case (req_data.mode)
         mbrm_pkg::MODE_RD_INPUT: begin
            sel_base  = input_base_ff;
            sel_limit = {1'b0, input_base_ff} + (AW+1)'(INPUT_REGS);
            sel_bits  = 1'b0;
         end
         mbrm_pkg::MODE_RD_HOLDING, mbrm_pkg::MODE_WR_HOLDING: begin
            sel_base  = holding_base_ff;
            sel_limit = {1'b0, holding_base_ff} + (AW+1)'(HOLDING_REGS);
            sel_bits  = 1'b0;
         end
         mbrm_pkg::MODE_RD_COILS, mbrm_pkg::MODE_WR_COILS: begin
            sel_base  = coil_base_ff;
            sel_limit = {1'b0, coil_base_ff} + (AW+1)'(COIL_BITS);
            sel_bits  = 1'b1;
         end
         default: begin
            sel_base  = discrete_base_ff;
            sel_limit = {1'b0, discrete_base_ff} + (AW+1)'(DISCRETE_BITS);
            sel_bits  = 1'b1;
         end
      endcase
   end

   assign end_addr   = {1'b0, req_data.address} + (AW+1)'(req_data.count);
   assign cnt_ok     = (req_data.count != '0) &&
                       (sel_bits ? ({1'b0, req_data.count} <= (CW+1)'(8 * MAX_RUN))
                                 : ({1'b0, req_data.count} <= (CW+1)'(MAX_RUN)));
   assign run_ok     = cnt_ok && (req_data.address >= sel_base) && (end_addr <= sel_limit);
   assign offset16   = req_data.address - sel_base;
   assign first_bits = (req_data.count > CW'(8)) ? 4'd8 : req_data.count[3:0];
   assign cont_bits  = (run_left_ff > CW'(8)) ? 4'd8 : run_left_ff[3:0];
   assign cont_match = run_open_ff && (run_left_ff != '0) && (req_data.mode == run_mode_ff);

   always_comb begin
      state_in        = state_ff;
      clr_ptr_in      = clr_ptr_ff;
      run_open_in     = run_open_ff;
      run_mode_in     = run_mode_ff;
      run_left_in     = run_left_ff;
      run_word_ptr_in = run_word_ptr_ff;
      run_bit_ptr_in  = run_bit_ptr_ff;
      eng_word_ptr_in = eng_word_ptr_ff;
      eng_bit_ptr_in  = eng_bit_ptr_ff;
      eng_left_in     = eng_left_ff;
      bit_idx_in      = bit_idx_ff;
      last_idx_in     = last_idx_ff;
      acc_in          = acc_ff;
      wbyte_in        = wbyte_ff;
      reply_in        = reply_ff;
      res_status_in   = res_status_ff;
      emit_last_in    = emit_last_ff;
      word_we         = 1'b0;
      word_waddr      = run_word_ptr_ff;
      word_wdata      = req_data.write_data;
      word_re         = 1'b0;
      word_raddr      = eng_word_ptr_ff;
      bit_we          = 1'b0;
      bit_waddr       = eng_bit_ptr_ff;
      bit_wdata       = wbyte_ff[bit_idx_ff];
      bit_re          = 1'b0;
      bit_raddr       = eng_bit_ptr_ff;
      emit            = 1'b0;
      emit_beat       = '{data: '0, status: res_status_ff, last: 1'b1};

      case (state_ff)
         mbrm_pkg::ST_CLEAR: begin
            word_we    = ({1'b0, clr_ptr_ff} < (CLR_W+1)'(WORD_DEPTH));
            word_waddr = clr_ptr_ff[WORD_AW-1:0];
            word_wdata = '0;
            bit_we     = ({1'b0, clr_ptr_ff} < (CLR_W+1)'(BIT_DEPTH));
            bit_waddr  = clr_ptr_ff[BIT_AW-1:0];
            bit_wdata  = 1'b0;
            clr_ptr_in = clr_ptr_ff + 1'b1;
            if (clr_ptr_ff == CLR_W'(CLEAR_LEN - 1)) begin
               state_in = mbrm_pkg::ST_IDLE;
            end
         end
         mbrm_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_data.mode)
                  mbrm_pkg::MODE_LOAD_INPUT: begin
                     res_status_in = !(req_data.address < AW'(INPUT_REGS));
                     word_we       = (req_data.address < AW'(INPUT_REGS));
                     word_waddr    = WORD_AW'(HOLDING_REGS) + req_data.address[WORD_AW-1:0];
                     state_in      = mbrm_pkg::ST_RESULT;
                  end
                  mbrm_pkg::MODE_LOAD_DISCRETE: begin
                     if (({1'b0, req_data.address} + (AW+1)'(8)) <=
                         (AW+1)'(DISCRETE_BITS)) begin
                        eng_bit_ptr_in = BIT_AW'(COIL_BITS) + req_data.address[BIT_AW-1:0];
                        wbyte_in       = req_data.write_data[7:0];
                        bit_idx_in     = 3'd0;
                        last_idx_in    = 3'd7;
                        reply_in       = 1'b1;
                        res_status_in  = 1'b0;
                        state_in       = mbrm_pkg::ST_BIT_WR;
                     end else begin
                        res_status_in = 1'b1;
                        state_in      = mbrm_pkg::ST_RESULT;
                     end
                  end
                  default: begin
                     if (req_data.start_req) begin
                        run_open_in = 1'b0;
                        run_left_in = '0;
                        if (!run_ok) begin
                           res_status_in = 1'b1;
                           state_in      = mbrm_pkg::ST_RESULT;
                        end else begin
                           case (req_data.mode)
                              mbrm_pkg::MODE_RD_INPUT: begin
                                 eng_word_ptr_in = WORD_AW'(HOLDING_REGS) +
                                                   offset16[WORD_AW-1:0];
                                 eng_left_in     = req_data.count;
                                 state_in        = mbrm_pkg::ST_WORD_RD;
                              end
                              mbrm_pkg::MODE_RD_HOLDING: begin
                                 eng_word_ptr_in = offset16[WORD_AW-1:0];
                                 eng_left_in     = req_data.count;
                                 state_in        = mbrm_pkg::ST_WORD_RD;
                              end
                              mbrm_pkg::MODE_WR_HOLDING: begin
                                 word_we         = 1'b1;
                                 word_waddr      = offset16[WORD_AW-1:0];
                                 run_mode_in     = req_data.mode;
                                 run_word_ptr_in = offset16[WORD_AW-1:0] + 1'b1;
                                 run_left_in     = req_data.count - 1'b1;
                                 if (req_data.count == CW'(1)) begin
                                    res_status_in = 1'b0;
                                    state_in      = mbrm_pkg::ST_RESULT;
                                 end else begin
                                    run_open_in = 1'b1;
                                 end
                              end
                              mbrm_pkg::MODE_RD_COILS: begin
                                 eng_bit_ptr_in = offset16[BIT_AW-1:0];
                                 eng_left_in    = req_data.count;
                                 bit_idx_in     = 3'd0;
                                 acc_in         = '0;
                                 state_in       = mbrm_pkg::ST_BIT_RD;
                              end
                              mbrm_pkg::MODE_WR_COILS: begin
                                 eng_bit_ptr_in = offset16[BIT_AW-1:0];
                                 wbyte_in       = req_data.write_data[7:0];
                                 bit_idx_in     = 3'd0;
                                 last_idx_in    = 3'(first_bits - 4'd1);
                                 run_mode_in    = req_data.mode;
                                 run_bit_ptr_in = offset16[BIT_AW-1:0] + BIT_AW'(first_bits);
                                 run_left_in    = req_data.count - CW'(first_bits);
                                 reply_in       = (req_data.count == CW'(first_bits));
                                 run_open_in    = (req_data.count != CW'(first_bits));
                                 res_status_in  = 1'b0;
                                 state_in       = mbrm_pkg::ST_BIT_WR;
                              end
                              default: begin
                                 eng_bit_ptr_in = BIT_AW'(COIL_BITS) + offset16[BIT_AW-1:0];
                                 eng_left_in    = req_data.count;
                                 bit_idx_in     = 3'd0;
                                 acc_in         = '0;
                                 state_in       = mbrm_pkg::ST_BIT_RD;
                              end
                           endcase
                        end
                     end else if (cont_match) begin
                        if (run_mode_ff == mbrm_pkg::MODE_WR_HOLDING) begin
                           word_we         = 1'b1;
                           word_waddr      = run_word_ptr_ff;
                           run_word_ptr_in = run_word_ptr_ff + 1'b1;
                           run_left_in     = run_left_ff - 1'b1;
                           if (run_left_ff == CW'(1)) begin
                              run_open_in   = 1'b0;
                              res_status_in = 1'b0;
                              state_in      = mbrm_pkg::ST_RESULT;
                           end
                        end else begin
                           eng_bit_ptr_in = run_bit_ptr_ff;
                           wbyte_in       = req_data.write_data[7:0];
                           bit_idx_in     = 3'd0;
                           last_idx_in    = 3'(cont_bits - 4'd1);
                           run_bit_ptr_in = run_bit_ptr_ff + BIT_AW'(cont_bits);
                           run_left_in    = run_left_ff - CW'(cont_bits);
                           reply_in       = (run_left_ff == CW'(cont_bits));
                           run_open_in    = (run_left_ff != CW'(cont_bits));
                           res_status_in  = 1'b0;
                           state_in       = mbrm_pkg::ST_BIT_WR;
                        end
                     end
                  end
               endcase
            end
         end
         mbrm_pkg::ST_WORD_RD: begin
            word_re  = 1'b1;
            state_in = mbrm_pkg::ST_WORD_DATA;
         end
         mbrm_pkg::ST_WORD_DATA: begin
            if (out_free) begin
               emit            = 1'b1;
               emit_beat       = '{data: word_rd_ff, status: 1'b0,
                                   last: (eng_left_ff == CW'(1))};
               eng_left_in     = eng_left_ff - 1'b1;
               eng_word_ptr_in = eng_word_ptr_ff + 1'b1;
               state_in        = (eng_left_ff == CW'(1)) ? mbrm_pkg::ST_IDLE
                                                         : mbrm_pkg::ST_WORD_RD;
            end
         end
         mbrm_pkg::ST_BIT_RD: begin
            bit_re   = 1'b1;
            state_in = mbrm_pkg::ST_BIT_TAKE;
         end
         mbrm_pkg::ST_BIT_TAKE: begin
            acc_in         = acc_ff | (8'(bit_rd_ff) << bit_idx_ff);
            eng_bit_ptr_in = eng_bit_ptr_ff + 1'b1;
            eng_left_in    = eng_left_ff - 1'b1;
            if ((eng_left_ff == CW'(1)) || (bit_idx_ff == 3'd7)) begin
               emit_last_in = (eng_left_ff == CW'(1));
               state_in     = mbrm_pkg::ST_BIT_EMIT;
            end else begin
               bit_idx_in = bit_idx_ff + 1'b1;
               state_in   = mbrm_pkg::ST_BIT_RD;
            end
         end
         mbrm_pkg::ST_BIT_EMIT: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_beat = '{data: DW'(acc_ff), status: 1'b0, last: emit_last_ff};
               acc_in    = '0;
               bit_idx_in = 3'd0;
               state_in  = emit_last_ff ? mbrm_pkg::ST_IDLE : mbrm_pkg::ST_BIT_RD;
            end
         end
         mbrm_pkg::ST_BIT_WR: begin
            bit_we         = 1'b1;
            eng_bit_ptr_in = eng_bit_ptr_ff + 1'b1;
            bit_idx_in     = bit_idx_ff + 1'b1;
            if (bit_idx_ff == last_idx_ff) begin
               state_in = reply_ff ? mbrm_pkg::ST_RESULT : mbrm_pkg::ST_IDLE;
            end
         end
         mbrm_pkg::ST_RESULT: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = mbrm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mbrm_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_beat_in  = emit ? emit_beat : rsp_beat_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= mbrm_pkg::ST_CLEAR;
         clr_ptr_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
         run_open_ff      <= 1'b0;
         run_mode_ff      <= mbrm_pkg::MODE_RD_INPUT;
         run_left_ff      <= '0;
         input_base_ff    <= mbrm_pkg::INPUT_BASE_RST;
         holding_base_ff  <= mbrm_pkg::HOLDING_BASE_RST;
         coil_base_ff     <= mbrm_pkg::COIL_BASE_RST;
         discrete_base_ff <= mbrm_pkg::DISCRETE_BASE_RST;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         run_open_ff  <= run_open_in;
         run_mode_ff  <= run_mode_in;
         run_left_ff  <= run_left_in;
         if (csr_we) begin
            case (csr_index)
               mbrm_pkg::CSR_INPUT_BASE:    input_base_ff    <= csr_wdata;
               mbrm_pkg::CSR_HOLDING_BASE:  holding_base_ff  <= csr_wdata;
               mbrm_pkg::CSR_COIL_BASE:     coil_base_ff     <= csr_wdata;
               mbrm_pkg::CSR_DISCRETE_BASE: discrete_base_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_beat_ff     <= rsp_beat_in;
      run_word_ptr_ff <= run_word_ptr_in;
      run_bit_ptr_ff  <= run_bit_ptr_in;
      eng_word_ptr_ff <= eng_word_ptr_in;
      eng_bit_ptr_ff  <= eng_bit_ptr_in;
      eng_left_ff     <= eng_left_in;
      bit_idx_ff      <= bit_idx_in;
      last_idx_ff     <= last_idx_in;
      acc_ff          <= acc_in;
      wbyte_ff        <= wbyte_in;
      reply_ff        <= reply_in;
      res_status_ff   <= res_status_in;
      emit_last_ff    <= emit_last_in;
   end

   always_ff @(posedge clock) begin
      if (word_we) begin
         word_mem_ff[word_waddr] <= word_wdata;
      end
      if (word_re) begin
         word_rd_ff <= word_mem_ff[word_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (bit_we) begin
         bit_mem_ff[bit_waddr] <= bit_wdata;
      end
      if (bit_re) begin
         bit_rd_ff <= bit_mem_ff[bit_raddr];
      end
   end

endmodule

// ===== rtl/mbrm_checker.sv =====
// Port-level assertions for the Modbus register map, bound to the top level.
module mbrm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input mbrm_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mbrm_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("block active right after reset");

   a_status_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |-> rsp_data.last && (rsp_data.data == 16'd0))
      else $error("refusal beat not final or carries data");

   a_load_reply: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.mode == mbrm_pkg::MODE_LOAD_INPUT)
      |=> !req_ready)
      else $error("input load did not hold off the next request");

endmodule

bind modbus_register_map mbrm_checker u_mbrm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
